### sv/vbps_pkg.sv
// Types, command codes and register defaults for the valve bypass pulse sequencer.
// No dependencies; used by every module of the block.
package vbps_pkg;

    localparam logic [15:0] CMD_NONE     = 16'd0;
    localparam logic [15:0] CMD_CLOSE    = 16'd8;
    localparam logic [15:0] CMD_OPEN     = 16'd9;
    localparam logic [15:0] CMD_SHUTDOWN = 16'd10;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd2;

    localparam logic        ENABLE_RESET = 1'b1;
    localparam logic [31:0] PULSE_RESET  = 32'd50;
    localparam logic [31:0] SETTLE_RESET = 32'd2000;

    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_CLOSE_PULSE = 3'd1,
        ST_OPEN_SETTLE = 3'd2,
        ST_OPEN_PULSE  = 3'd3,
        ST_SHUT_PULSE  = 3'd4
    } t_seq_state;

    typedef struct packed {
        logic [15:0] command;
        logic [31:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic valve_close;
        logic bypass_open_pulse;
        logic bypass_close_pulse;
        logic bypass_status;
    } t_out_item;

    typedef struct packed {
        t_seq_state  state;
        logic [15:0] pending_command;
        logic [31:0] deadline;
        logic        valve_line;
        logic        open_line;
        logic        close_line;
        logic        status_bit;
    } t_seq_regs;

    typedef struct packed {
        logic        enable;
        logic [31:0] pulse_counts;
        logic [31:0] settle_counts;
    } t_cfg_regs;

endpackage

### sv/vbps_step.sv
// Next-state logic of the sequencer for one transaction.
// Depends on vbps_pkg.
module vbps_step
    import vbps_pkg::*;
(
    input  t_seq_regs i_cur,
    input  t_cfg_regs i_cfg,
    input  t_in_item  i_item,
    output t_seq_regs o_next,
    output t_out_item o_result
);

    logic [15:0] pend;
    logic        past;

    assign past = i_item.time_now > i_cur.deadline;

    always_comb begin
        o_next = i_cur;
        pend   = i_cur.pending_command;
        if (i_cfg.enable) begin
            if (i_item.command != CMD_NONE) begin
                pend = i_item.command;
            end
            o_next.pending_command = pend;
            case (i_cur.state)
                ST_IDLE: begin
                    o_next.pending_command = CMD_NONE;
                    if (pend == CMD_CLOSE) begin
                        o_next.valve_line = 1'b1;
                        o_next.open_line  = 1'b1;
                        o_next.deadline   = i_item.time_now + i_cfg.pulse_counts;
                        o_next.state      = ST_CLOSE_PULSE;
                    end else if (pend == CMD_OPEN) begin
                        o_next.valve_line = 1'b0;
                        o_next.deadline   = i_item.time_now + i_cfg.settle_counts;
                        o_next.state      = ST_OPEN_SETTLE;
                    end else if (pend == CMD_SHUTDOWN) begin
                        o_next.valve_line = 1'b1;
                        o_next.close_line = 1'b1;
                        o_next.deadline   = i_item.time_now + i_cfg.pulse_counts;
                        o_next.state      = ST_SHUT_PULSE;
                    end
                end
                ST_CLOSE_PULSE: begin
                    if (past) begin
                        o_next.open_line  = 1'b0;
                        o_next.status_bit = 1'b1;
                        o_next.state      = ST_IDLE;
                    end
                end
                ST_OPEN_SETTLE: begin
                    if (past) begin
                        o_next.close_line = 1'b1;
                        o_next.deadline   = i_item.time_now + i_cfg.pulse_counts;
                        o_next.state      = ST_OPEN_PULSE;
                    end
                end
                ST_OPEN_PULSE, ST_SHUT_PULSE: begin
                    if (past) begin
                        o_next.close_line = 1'b0;
                        o_next.status_bit = 1'b0;
                        o_next.state      = ST_IDLE;
                    end
                end
                default: begin
                    o_next.state = ST_IDLE;
                end
            endcase
        end
    end

    assign o_result.valve_close        = o_next.valve_line;
    assign o_result.bypass_open_pulse  = o_next.open_line;
    assign o_result.bypass_close_pulse = o_next.close_line;
    assign o_result.bypass_status      = o_next.status_bit;

endmodule

### sv/valve_bypass_pulse_sequencer_core.sv
// Valve bypass pulse sequencer: input register, state update, result register.
// Input register holds an accepted item until the result register frees up.
// Throughput: one transaction per cycle unless the output stalls; the state
// update uses 32-bit adds and one 32-bit compare in vbps_step.
// Reset: synchronous, active low; clears sequencer state, pipeline valids and
// loads register defaults (enable 1, pulse 50, settle 2000).
module valve_bypass_pulse_sequencer_core
    import vbps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg_regs r_cfg;
    t_seq_regs r_seq;
    t_seq_regs n_seq;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      out_free;
    logic      step_fire;

    assign out_free    = !r_out_valid || i_out_ready;
    assign step_fire   = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    vbps_step u_step (
        .i_cur    (r_seq),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_next   (n_seq),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= ENABLE_RESET;
            r_cfg.pulse_counts  <= PULSE_RESET;
            r_cfg.settle_counts <= SETTLE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE: r_cfg.enable        <= i_cfg_data[0];
                CFG_PULSE:  r_cfg.pulse_counts  <= i_cfg_data;
                CFG_SETTLE: r_cfg.settle_counts <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq.state           <= ST_IDLE;
            r_seq.pending_command <= CMD_NONE;
            r_seq.deadline        <= '0;
            r_seq.valve_line      <= 1'b0;
            r_seq.open_line       <= 1'b0;
            r_seq.close_line      <= 1'b0;
            r_seq.status_bit      <= 1'b0;
            r_out_valid           <= 1'b0;
        end else if (step_fire) begin
            r_seq       <= n_seq;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= n_out;
        end
    end

endmodule

### sv/vbps_checker.sv
// Port-level checks for the valve bypass pulse sequencer, bound to the top level.
// Depends on vbps_pkg and valve_bypass_pulse_sequencer_core.
module vbps_checker
    import vbps_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.bypass_open_pulse && o_out_data.bypass_close_pulse))
        else $error("both bypass drivers high");

    a_open_pulse_valve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bypass_open_pulse |-> o_out_data.valve_close)
        else $error("bypass open pulse without valve closed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind valve_bypass_pulse_sequencer_core vbps_checker u_vbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
